### rtl/mh64b_pkg.sv
`timescale 1ns / 1ps

package mh64b_pkg;

  // Mixing constant and shift amounts of MurmurHash64B.
  localparam logic [31:0] MixMul   = 32'h5bd1e995;
  localparam int unsigned MixShift = 24;
  localparam int unsigned FinShA   = 18;
  localparam int unsigned FinShB   = 22;
  localparam int unsigned FinShC   = 17;
  localparam int unsigned FinShD   = 19;

  localparam logic [63:0] SeedReset = 64'h0000_0000_DEAD_BEEF;

  // A byte count of this value or above means a whole word.
  localparam logic [2:0] ByteCntFull = 3'd4;

  // Queue between the front and the back.
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_FULL,
    KIND_TAIL
  } kind_e;

  // One classified beat, as the back executes it.
  typedef struct packed {
    logic [31:0] word;
    kind_e       kind;
    logic        first;
    logic        last;
    logic [31:0] total_length;
  } op_t;

  typedef struct packed {
    logic [QCntW-1:0] count;
    logic             empty;
    logic             full;
  } qstat_t;

  typedef struct packed {
    logic busy;
    logic pop;
  } bstat_t;

endpackage

### rtl/mh64b_ifs.sv
`timescale 1ns / 1ps

// Message beat channel.
interface mh64b_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] word;
  logic [2:0]  byte_count;
  logic        first;
  logic        last;
  logic [31:0] total_length;

  modport source (
    output valid, word, byte_count, first, last, total_length,
    input  ready
  );
  modport sink (
    input  valid, word, byte_count, first, last, total_length,
    output ready
  );
endinterface

// Digest channel.
interface mh64b_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest;

  modport source (output valid, digest, input ready);
  modport sink (input valid, digest, output ready);
endinterface

// Seed write channel.
interface mh64b_cfg_if;
  logic        valid;
  logic        ready;
  logic [63:0] seed;

  modport source (output valid, seed, input ready);
  modport sink (input valid, seed, output ready);
endinterface

### rtl/mh64b_front.sv
`timescale 1ns / 1ps

module mh64b_front (
  mh64b_in_if.sink           in_i,
  input  logic               q_full_i,
  output logic               push_o,
  output mh64b_pkg::op_t     op_o
);
  import mh64b_pkg::*;

  logic [31:0] tail_mask;

  // Keep only the valid bytes of a partial word.
  always_comb begin
    unique case (in_i.byte_count)
      3'd1:    tail_mask = 32'h0000_00FF;
      3'd2:    tail_mask = 32'h0000_FFFF;
      3'd3:    tail_mask = 32'h00FF_FFFF;
      default: tail_mask = 32'h0000_0000;
    endcase
  end

  always_comb begin
    op_o.first        = in_i.first;
    op_o.last         = in_i.last;
    op_o.total_length = in_i.total_length;
    if (in_i.byte_count >= ByteCntFull) begin
      op_o.kind = KIND_FULL;
      op_o.word = in_i.word;
    end else if (in_i.byte_count == 3'd0) begin
      op_o.kind = KIND_NONE;
      op_o.word = 32'h0;
    end else begin
      op_o.kind = KIND_TAIL;
      op_o.word = in_i.word & tail_mask;
    end
  end

  assign in_i.ready = !q_full_i;
  assign push_o     = in_i.valid && !q_full_i;

endmodule

### rtl/mh64b_queue.sv
`timescale 1ns / 1ps

module mh64b_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  mh64b_pkg::op_t     op_i,
  input  logic               pop_i,
  output mh64b_pkg::op_t     op_o,
  output mh64b_pkg::qstat_t  stat_o
);
  import mh64b_pkg::*;

  op_t              mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign stat_o.count = count_q;
  assign stat_o.empty = (count_q == '0);
  assign stat_o.full  = (count_q == QCntW'(QueueDepth));

  assign do_push = push_i && !stat_o.full;
  assign do_pop  = pop_i && !stat_o.empty;

  assign op_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= op_i;
    end
  end

endmodule

### rtl/mh64b_back.sv
`timescale 1ns / 1ps

module mh64b_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [63:0]        seed_i,
  input  mh64b_pkg::op_t     op_i,
  input  logic               q_empty_i,
  mh64b_out_if.source        out_o,
  output mh64b_pkg::bstat_t  stat_o
);
  import mh64b_pkg::*;

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_K1   = 4'd1;
  localparam logic [3:0] ST_K2   = 4'd2;
  localparam logic [3:0] ST_ACC  = 4'd3;
  localparam logic [3:0] ST_TAIL = 4'd4;
  localparam logic [3:0] ST_F1   = 4'd5;
  localparam logic [3:0] ST_F2   = 4'd6;
  localparam logic [3:0] ST_F3   = 4'd7;
  localparam logic [3:0] ST_F4   = 4'd8;

  logic [3:0]  state_q, state_d;
  logic [31:0] acc_one_q, acc_one_d;
  logic [31:0] acc_two_q, acc_two_d;
  logic        parity_q, parity_d;
  logic [31:0] k_q, k_d;
  logic [31:0] h1_q, h1_d;
  logic [31:0] h2_q, h2_d;
  op_t         cur_q, cur_d;
  logic [63:0] dig_q, dig_d;
  logic        dig_vld_q, dig_vld_d;
  logic        pop;
  logic [31:0] mul_a, mul_p;

  // The one multiplier of the block, shared by every step.
  assign mul_p = mul_a * MixMul;

  always_comb begin
    state_d   = state_q;
    acc_one_d = acc_one_q;
    acc_two_d = acc_two_q;
    parity_d  = parity_q;
    k_d       = k_q;
    h1_d      = h1_q;
    h2_d      = h2_q;
    cur_d     = cur_q;
    dig_d     = dig_q;
    dig_vld_d = dig_vld_q && !out_o.ready;
    pop       = 1'b0;
    mul_a     = 32'h0;

    unique case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          pop   = 1'b1;
          cur_d = op_i;
          if (op_i.first) begin
            acc_one_d = seed_i[31:0] ^ op_i.total_length;
            acc_two_d = seed_i[63:32];
            parity_d  = 1'b0;
          end
          case (op_i.kind)
            KIND_FULL: state_d = ST_K1;
            KIND_TAIL: state_d = ST_TAIL;
            default:   state_d = op_i.last ? ST_F1 : ST_IDLE;
          endcase
        end
      end
      ST_K1: begin
        mul_a   = cur_q.word;
        k_d     = mul_p;
        state_d = ST_K2;
      end
      ST_K2: begin
        mul_a   = k_q ^ (k_q >> MixShift);
        k_d     = mul_p;
        state_d = ST_ACC;
      end
      ST_ACC: begin
        mul_a = parity_q ? acc_two_q : acc_one_q;
        if (parity_q) begin
          acc_two_d = mul_p ^ k_q;
        end else begin
          acc_one_d = mul_p ^ k_q;
        end
        parity_d = ~parity_q;
        state_d  = cur_q.last ? ST_F1 : ST_IDLE;
      end
      ST_TAIL: begin
        mul_a     = acc_two_q ^ cur_q.word;
        acc_two_d = mul_p;
        state_d   = cur_q.last ? ST_F1 : ST_IDLE;
      end
      ST_F1: begin
        mul_a   = acc_one_q ^ (acc_two_q >> FinShA);
        h1_d    = mul_p;
        h2_d    = acc_two_q;
        state_d = ST_F2;
      end
      ST_F2: begin
        mul_a   = h2_q ^ (h1_q >> FinShB);
        h2_d    = mul_p;
        state_d = ST_F3;
      end
      ST_F3: begin
        mul_a   = h1_q ^ (h2_q >> FinShC);
        h1_d    = mul_p;
        state_d = ST_F4;
      end
      ST_F4: begin
        mul_a = h2_q ^ (h1_q >> FinShD);
        // Wait here until the output register is free or being drained.
        if (!dig_vld_q || out_o.ready) begin
          dig_d     = {h1_q, mul_p};
          dig_vld_d = 1'b1;
          parity_d  = 1'b0;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      acc_one_q <= 32'h0;
      acc_two_q <= 32'h0;
      parity_q  <= 1'b0;
      dig_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      acc_one_q <= acc_one_d;
      acc_two_q <= acc_two_d;
      parity_q  <= parity_d;
      dig_vld_q <= dig_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q   <= k_d;
    h1_q  <= h1_d;
    h2_q  <= h2_d;
    cur_q <= cur_d;
    dig_q <= dig_d;
  end

  assign out_o.valid  = dig_vld_q;
  assign out_o.digest = dig_q;

  assign stat_o.busy = (state_q != ST_IDLE);
  assign stat_o.pop  = pop;

endmodule

### rtl/murmur_hash_64b_stream_unit.sv
`timescale 1ns / 1ps

// MurmurHash64B streaming unit. A message enters as little-endian 32-bit
// beats on in_i; the beat marked first also carries the total byte length,
// which is XORed with the low seed half to start the first accumulator, and
// the high seed half starts the second. Full words alternate between the two
// accumulators, a final partial word of one to three bytes folds into the
// second, and after the beat marked last one 64-bit digest beat leaves on
// out_o, first accumulator in the upper half. The seed is written on cfg_i,
// which is always ready, and must only be changed while the unit is idle;
// it resets to 0xDEADBEEF. A front stage classifies each beat and places it
// in a two-entry queue, so the input keeps accepting while the back is busy
// until the queue is full. The back owns one 32-by-32 multiplier and runs
// every step through it, one multiply per cycle while no digest waits: a
// beat first leaves the queue, a full word is then mixed and folded into
// its accumulator, a partial word is folded in directly, and a last beat
// adds four finalization rounds. The back takes the next beat only once it
// is through with the last. A digest that is not taken holds the back in its
// final round while the queue fills. Nothing needs clearing after reset.
module murmur_hash_64b_stream_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  mh64b_in_if.sink     in_i,
  mh64b_cfg_if.sink    cfg_i,
  mh64b_out_if.source  out_o
);
  import mh64b_pkg::*;

  logic [63:0] seed_q;
  logic        push;
  op_t         push_op;
  op_t         head_op;
  qstat_t      q_stat;
  bstat_t      b_stat;

  // Seed register; writes are accepted in any cycle.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= SeedReset;
    end else if (cfg_i.valid) begin
      seed_q <= cfg_i.seed;
    end
  end

  mh64b_front u_front (
    .in_i     (in_i),
    .q_full_i (q_stat.full),
    .push_o   (push),
    .op_o     (push_op)
  );

  mh64b_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .op_i   (push_op),
    .pop_i  (b_stat.pop),
    .op_o   (head_op),
    .stat_o (q_stat)
  );

  mh64b_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .seed_i    (seed_q),
    .op_i      (head_op),
    .q_empty_i (q_stat.empty),
    .out_o     (out_o),
    .stat_o    (b_stat)
  );

  // The back never takes a beat from an empty queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_stat.pop |-> !q_stat.empty)
    else $error("back popped an empty queue");

  // The queue occupancy never exceeds its depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_stat.count <= QCntW'(QueueDepth))
    else $error("queue occupancy beyond depth");

  // A new digest only appears at the end of a finalization.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_o.valid) |-> $past(b_stat.busy))
    else $error("digest appeared without back activity");

  // A beat popped by the back leaves the queue one entry emptier unless
  // a new beat was pushed at the same edge.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (b_stat.pop && !push) |=> (q_stat.count == $past(q_stat.count) - 1'b1))
    else $error("queue count did not follow a pop");

endmodule
